[hdl/sll_pkg.sv]
package sll_pkg;

    localparam int NODE_COUNT_DEF = 32;
    localparam int LIST_COUNT_DEF = 2;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_ERASE   = 3'd1;
    localparam logic [2:0] OP_PUSH    = 3'd2;
    localparam logic [2:0] OP_POP     = 3'd3;
    localparam logic [2:0] OP_READOUT = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic               list_select;
        logic [5:0]         position;
        logic signed [31:0] item_value;
    } sll_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         slot_index;
        logic signed [31:0] element_value;
        logic [5:0]         list_length;
        logic               is_last;
    } sll_out_t;

endpackage

[hdl/sll_alloc.sv]
// Lowest-free-slot search, scanned one slot per cycle.
module sll_alloc #(
    parameter int NODE_COUNT = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          scan_start,
    input  logic [NODE_COUNT-1:0]         used_map,
    output logic                          scan_done,
    output logic [$clog2(NODE_COUNT)-1:0] free_slot
);
    localparam int AW = $clog2(NODE_COUNT);

    logic          busy_reg, busy_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          done_reg, done_next;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        done_next = 1'b0;
        if (scan_start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!used_map[idx_reg])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

    assign scan_done = done_reg;
    assign free_slot = idx_reg;
endmodule

[hdl/static_linked_list_engine.sv]
// Several singly linked lists share one store of NODE_COUNT nodes; a new node
// always takes the lowest free slot. A transaction is taken when start is high
// and busy low; busy then stays high until the cycle in which the last result
// is shown. Results appear for one cycle each with result_valid set and cannot
// be held off, so the receiver must take every one. Insert and erase walk the
// list one link per cycle through the node store, and allocation scans the used
// map one slot per cycle; a read out checks the list and then shows its elements
// in order from the head.
module static_linked_list_engine #(
    parameter int NODE_COUNT = sll_pkg::NODE_COUNT_DEF,
    parameter int LIST_COUNT = sll_pkg::LIST_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sll_pkg::sll_in_t  command,
    output logic              busy,
    output logic              result_valid,
    output sll_pkg::sll_out_t result
);
    import sll_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int CW = $clog2(NODE_COUNT + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_ALLOC = 9'b000000100,
        S_WALK  = 9'b000001000,
        S_LINK  = 9'b000010000,
        S_ERASE = 9'b000100000,
        S_RDREQ = 9'b001000000,
        S_RDOUT = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]           mem_val [NODE_COUNT];
    logic [AW-1:0]         mem_link[NODE_COUNT];
    logic [NODE_COUNT-1:0] used_reg, used_next;
    logic [AW-1:0]         head_reg[LIST_COUNT];
    logic [CW-1:0]         size_reg[LIST_COUNT];

    sll_in_t       cmd_reg;
    logic [LW-1:0] lsel;
    logic          lsel_ok;
    logic [CW-1:0] cur_size;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] fresh_reg, fresh_next;
    logic          is_ins;
    logic          alloc_start, alloc_done;
    logic [AW-1:0] alloc_slot;

    // Registered reads from the store.
    logic [31:0]   rd_val;
    logic [AW-1:0] rd_link;
    logic [AW-1:0] rd_addr;

    // Store write requests.
    logic          wv_en, wl_en;
    logic [AW-1:0] wv_addr, wl_addr;
    logic [AW-1:0] wl_data;
    logic          head_we, size_inc, size_dec;
    logic [AW-1:0] head_data;

    sll_out_t res_reg, res_next;
    logic     rv_reg, rv_next;

    sll_alloc #(.NODE_COUNT(NODE_COUNT)) u_alloc (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_start (alloc_start),
        .used_map   (used_reg),
        .scan_done  (alloc_done),
        .free_slot  (alloc_slot)
    );

    assign lsel     = LW'(cmd_reg.list_select);
    assign lsel_ok  = (32'(cmd_reg.list_select) < LIST_COUNT);
    assign cur_size = lsel_ok ? size_reg[lsel] : '0;
    assign is_ins   = (cmd_reg.operation == OP_INSERT) || (cmd_reg.operation == OP_PUSH);

    function automatic sll_out_t mk(input logic [1:0] st, input logic [AW-1:0] sl,
                                    input logic [31:0] v, input logic [CW-1:0] len,
                                    input logic last);
        sll_out_t r;
        r.status        = st;
        r.slot_index    = 5'(sl);
        r.element_value = v;
        r.list_length   = 6'(len);
        r.is_last       = last;
        return r;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        fresh_next  = fresh_reg;
        res_next    = res_reg;
        rv_next     = 1'b0;
        alloc_start = 1'b0;
        rd_addr     = ptr_reg;
        wv_en       = 1'b0;
        wl_en       = 1'b0;
        wv_addr     = fresh_reg;
        wl_addr     = ptr_reg;
        wl_data     = fresh_reg;
        head_we     = 1'b0;
        head_data   = fresh_reg;
        size_inc    = 1'b0;
        size_dec    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_EMIT;
                if (!lsel_ok)
                begin
                    res_next = mk(ST_RANGE, '0, '0, '0, 1'b1);
                end
                else
                begin
                    case (cmd_reg.operation)
                        OP_INSERT, OP_PUSH:
                        begin
                            pos_next = (cmd_reg.operation == OP_PUSH) ? cur_size
                                                                      : CW'(cmd_reg.position);
                            if (32'(cur_size) >= NODE_COUNT)
                            begin
                                res_next = mk(ST_FULL, '0, '0, cur_size, 1'b1);
                            end
                            else if (cmd_reg.operation == OP_INSERT &&
                                     7'(cmd_reg.position) > 7'(cur_size))
                            begin
                                res_next = mk(ST_RANGE, '0, '0, cur_size, 1'b1);
                            end
                            else if (&used_reg)
                            begin
                                res_next = mk(ST_FULL, '0, '0, cur_size, 1'b1);
                            end
                            else
                            begin
                                alloc_start = 1'b1;
                                state_next  = S_ALLOC;
                            end
                        end
                        OP_ERASE, OP_POP:
                        begin
                            pos_next = (cmd_reg.operation == OP_POP) ? cur_size - CW'(1)
                                                                     : CW'(cmd_reg.position);
                            if (cmd_reg.operation == OP_POP && cur_size == '0)
                            begin
                                res_next = mk(ST_RANGE, '0, '0, '0, 1'b1);
                            end
                            else if (cmd_reg.operation == OP_ERASE &&
                                     7'(cmd_reg.position) >= 7'(cur_size))
                            begin
                                res_next = mk(ST_RANGE, '0, '0, cur_size, 1'b1);
                            end
                            else
                            begin
                                ptr_next   = head_reg[lsel];
                                cnt_next   = '0;
                                rd_addr    = head_reg[lsel];
                                state_next = S_WALK;
                            end
                        end
                        OP_READOUT:
                        begin
                            if (cur_size == '0)
                            begin
                                res_next = mk(ST_RANGE, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                ptr_next   = head_reg[lsel];
                                cnt_next   = '0;
                                rd_addr    = head_reg[lsel];
                                state_next = S_RDOUT;
                            end
                        end
                        default:
                        begin
                            res_next = mk(ST_RANGE, '0, '0, cur_size, 1'b1);
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (alloc_done)
                begin
                    fresh_next = alloc_slot;
                    used_next[alloc_slot] = 1'b1;
                    ptr_next   = head_reg[lsel];
                    cnt_next   = '0;
                    rd_addr    = head_reg[lsel];
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // ptr_reg is the node at position cnt_reg; rd_link its link.
                if (pos_reg == '0)
                begin
                    state_next = is_ins ? S_LINK : S_ERASE;
                end
                else if (cnt_reg + CW'(1) == pos_reg)
                begin
                    state_next = is_ins ? S_LINK : S_ERASE;
                end
                else
                begin
                    ptr_next = rd_link;
                    cnt_next = cnt_reg + CW'(1);
                    rd_addr  = rd_link;
                end
            end
            S_LINK:
            begin
                wv_en   = 1'b1;
                wv_addr = fresh_reg;
                wl_en   = 1'b1;
                if (pos_reg == '0)
                begin
                    wl_addr   = fresh_reg;
                    wl_data   = (cur_size != '0) ? head_reg[lsel] : '0;
                    head_we   = 1'b1;
                    head_data = fresh_reg;
                end
                else
                begin
                    // New node takes prev's link first; prev is rewritten next.
                    wl_addr = fresh_reg;
                    wl_data = rd_link;
                end
                size_inc   = 1'b1;
                res_next   = mk(ST_OK, fresh_reg, '0, cur_size + CW'(1), 1'b1);
                state_next = (pos_reg == '0) ? S_EMIT : S_ERASE;
            end
            S_ERASE:
            begin
                if (is_ins)
                begin
                    wl_en      = 1'b1;
                    wl_addr    = ptr_reg;
                    wl_data    = fresh_reg;
                    state_next = S_EMIT;
                end
                else if (pos_reg == '0)
                begin
                    head_we   = 1'b1;
                    head_data = rd_link;
                    used_next[ptr_reg] = 1'b0;
                    size_dec   = 1'b1;
                    res_next   = mk(ST_OK, ptr_reg, '0, cur_size - CW'(1), 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    // Fetch the victim's link, then splice in S_RDREQ.
                    fresh_next = rd_link;
                    rd_addr    = rd_link;
                    state_next = S_RDREQ;
                end
            end
            S_RDREQ:
            begin
                wl_en   = 1'b1;
                wl_addr = ptr_reg;
                wl_data = rd_link;
                used_next[fresh_reg] = 1'b0;
                size_dec   = 1'b1;
                res_next   = mk(ST_OK, fresh_reg, '0, cur_size - CW'(1), 1'b1);
                state_next = S_EMIT;
            end
            S_RDOUT:
            begin
                rv_next  = 1'b1;
                res_next = mk(ST_OK, '0, rd_val, cur_size, cnt_reg + CW'(1) == cur_size);
                ptr_next = rd_link;
                cnt_next = cnt_reg + CW'(1);
                rd_addr  = rd_link;
                if (cnt_reg + CW'(1) == cur_size)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                rv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_val  <= mem_val[rd_addr];
        rd_link <= mem_link[rd_addr];
        if (wv_en)
        begin
            mem_val[wv_addr] <= cmd_reg.item_value;
        end
        if (wl_en)
        begin
            mem_link[wl_addr] <= wl_data;
        end
        if (start && state_reg == S_IDLE)
        begin
            cmd_reg <= command;
        end
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        ptr_reg   <= ptr_next;
        fresh_reg <= fresh_next;
        res_reg   <= res_next;
        if (head_we)
        begin
            head_reg[lsel] <= head_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                size_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            rv_reg    <= rv_next;
            if (size_inc)
            begin
                size_reg[lsel] <= size_reg[lsel] + CW'(1);
            end
            else if (size_dec)
            begin
                size_reg[lsel] <= size_reg[lsel] - CW'(1);
            end
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;
endmodule

[hdl/sll_checker.sv]
module sll_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input sll_pkg::sll_out_t result
);
    import sll_pkg::*;

    // A transaction always makes the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // The final result of a transaction releases busy.
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_last |-> !busy)
        else $error("busy held after final result");

    // A result that is not the last leaves the block busy.
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_last |-> busy)
        else $error("block idle before final result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status == ST_OK || result.status == ST_RANGE ||
                         result.status == ST_FULL)
        else $error("undefined status code");
endmodule

bind static_linked_list_engine sll_checker u_sll_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import sll_pkg::*;

    localparam int NODES = 32;
    localparam int LISTS = 2;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    sll_in_t  command = '0;
    logic     busy;
    logic     result_valid;
    sll_out_t result;

    static_linked_list_engine dut (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .busy(busy), .result_valid(result_valid), .result(result)
    );

    always #5 clk = ~clk;

    // Shadow copy of the shared node store.
    logic [31:0] node_val [NODES];
    logic [4:0]  node_next [NODES];
    logic [NODES-1:0] used_map;
    int unsigned free_nodes;
    logic [4:0]  head [LISTS];
    int unsigned size [LISTS];

    sll_in_t  pending_cmds [$];
    sll_out_t expected_results [$];
    int       error_count = 0;
    bit       no_idle = 1'b0;
    bit       hold_sender = 1'b0;
    bit       stimulus_done = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_result(input logic [1:0] st, input logic [4:0] slot,
                               input logic [31:0] v, input int unsigned len,
                               input logic last);
        sll_out_t r;
        r.status = st;
        r.slot_index = slot;
        r.element_value = v;
        r.list_length = len[5:0];
        r.is_last = last;
        expected_results.push_back(r);
    endtask

    function automatic logic [4:0] step_from(input int l, input int unsigned n);
        logic [4:0] s;
        s = head[l];
        for (int i = 0; i < n; i++)
            s = node_next[s];
        return s;
    endfunction

    task automatic list_insert(input int l, input int unsigned pos,
                               input logic [31:0] v);
        logic [4:0] fresh, prev;
        if (size[l] >= NODES || (pos <= size[l] && free_nodes == 0))
            push_result(ST_FULL, '0, '0, size[l], 1'b1);
        else if (pos > size[l])
            push_result(ST_RANGE, '0, '0, size[l], 1'b1);
        else
        begin
            fresh = '0;
            for (int i = NODES - 1; i >= 0; i--)
                if (!used_map[i])
                    fresh = i[4:0];
            used_map[fresh] = 1'b1;
            free_nodes--;
            node_val[fresh] = v;
            if (pos == 0)
            begin
                node_next[fresh] = (size[l] != 0) ? head[l] : 5'd0;
                head[l] = fresh;
            end
            else
            begin
                prev = step_from(l, pos - 1);
                node_next[fresh] = node_next[prev];
                node_next[prev] = fresh;
            end
            size[l]++;
            push_result(ST_OK, fresh, '0, size[l], 1'b1);
        end
    endtask

    task automatic list_erase(input int l, input int unsigned pos);
        logic [4:0] victim, prev;
        if (pos >= size[l])
            push_result(ST_RANGE, '0, '0, size[l], 1'b1);
        else
        begin
            if (pos == 0)
            begin
                victim = head[l];
                head[l] = node_next[victim];
            end
            else
            begin
                prev = step_from(l, pos - 1);
                victim = node_next[prev];
                node_next[prev] = node_next[victim];
            end
            if (used_map[victim])
            begin
                used_map[victim] = 1'b0;
                free_nodes++;
            end
            size[l]--;
            push_result(ST_OK, victim, '0, size[l], 1'b1);
        end
    endtask

    task automatic predict_command(input sll_in_t c);
        int l;
        logic [4:0] s;
        l = int'(c.list_select);
        case (c.operation)
            OP_INSERT:  list_insert(l, c.position, c.item_value);
            OP_ERASE:   list_erase(l, c.position);
            OP_PUSH:    list_insert(l, size[l], c.item_value);
            OP_POP:
                if (size[l] == 0)
                    push_result(ST_RANGE, '0, '0, 0, 1'b1);
                else
                    list_erase(l, size[l] - 1);
            OP_READOUT:
                if (size[l] == 0)
                    push_result(ST_RANGE, '0, '0, 0, 1'b1);
                else
                begin
                    s = head[l];
                    for (int i = 0; i < size[l]; i++)
                    begin
                        push_result(ST_OK, '0, node_val[s], size[l], i + 1 == size[l]);
                        s = node_next[s];
                    end
                end
            default:    push_result(ST_RANGE, '0, '0, size[l], 1'b1);
        endcase
    endtask

    task automatic queue_cmd(input logic [2:0] op, input logic l,
                             input logic [5:0] pos, input logic [31:0] v);
        sll_in_t c;
        c.operation = op;
        c.list_select = l;
        c.position = pos;
        c.item_value = v;
        pending_cmds.push_back(c);
    endtask

    // Driver: one transaction per accepted start, with random idle bursts.
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // The accepted transaction leaves the queue, so the head is next.
            if (start && !busy)
            begin
                predict_command(command);
                void'(pending_cmds.pop_front());
            end
            if (start && busy)
                ;
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                start <= 1'b0;
            end
            else if (hold_sender || pending_cmds.size() == 0)
                start <= 1'b0;
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                send_gap <= $urandom_range(1, 15) - 1;
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                command <= pending_cmds[0];
            end
        end
    end

    // Monitor: every strobed result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        sll_out_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d",
                                              result.status, want.status));
                if (result.slot_index !== want.slot_index)
                    report_mismatch($sformatf("slot %0d want %0d",
                                              result.slot_index, want.slot_index));
                if (result.element_value !== want.element_value)
                    report_mismatch($sformatf("value %h want %h",
                                              result.element_value, want.element_value));
                if (result.list_length !== want.list_length)
                    report_mismatch($sformatf("length %0d want %0d",
                                              result.list_length, want.list_length));
                if (result.is_last !== want.is_last)
                    report_mismatch($sformatf("last %0d want %0d",
                                              result.is_last, want.is_last));
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        used_map = '0;
        free_nodes = NODES;
        for (int i = 0; i < NODES; i++)
        begin
            node_val[i] = '0;
            node_next[i] = '0;
        end
        for (int l = 0; l < LISTS; l++)
        begin
            head[l] = '0;
            size[l] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-list cases, extremes, every operation, bad codes.
        queue_cmd(OP_POP, 0, 0, 0);
        queue_cmd(OP_READOUT, 1, 0, 0);
        queue_cmd(OP_ERASE, 0, 0, 0);
        queue_cmd(OP_INSERT, 0, 1, 32'h1);
        queue_cmd(OP_INSERT, 0, 0, 32'h8000_0000);
        queue_cmd(OP_PUSH, 0, 0, 32'h7fff_ffff);
        queue_cmd(OP_INSERT, 0, 1, 32'hffff_ffff);
        queue_cmd(OP_PUSH, 1, 63, 32'h5555_aaaa);
        queue_cmd(OP_READOUT, 0, 0, 0);
        queue_cmd(OP_ERASE, 0, 3, 0);
        queue_cmd(OP_ERASE, 0, 1, 0);
        queue_cmd(3'd5, 0, 0, 0);
        queue_cmd(3'd6, 1, 63, 32'hffff_ffff);
        queue_cmd(3'd7, 0, 5, 0);
        queue_cmd(OP_INSERT, 1, 63, 0);
        queue_cmd(OP_POP, 1, 0, 0);
        queue_cmd(OP_READOUT, 0, 0, 0);
        wait_drained();

        // Fill the whole store across both lists, then probe the full cases.
        for (int i = 0; i < 30; i++)
            queue_cmd(OP_PUSH, i[0], 0, $urandom);
        queue_cmd(OP_INSERT, 1, 0, 32'h1234);
        queue_cmd(OP_PUSH, 0, 0, 32'h4321);
        queue_cmd(OP_READOUT, 0, 0, 0);
        queue_cmd(OP_INSERT, 0, 0, 32'h9);
        queue_cmd(OP_ERASE, 1, 8, 0);
        queue_cmd(OP_READOUT, 1, 0, 0);
        wait_drained();
        hold_sender = 1'b1;
        repeat (40) @(posedge clk);
        hold_sender = 1'b0;

        // Random: mostly in-range positions, some beyond the list.
        for (int i = 0; i < 450; i++)
        begin
            int r;
            logic l;
            logic [5:0] pos;
            logic [2:0] op;
            if (i == 380)
            begin
                wait_drained();
                no_idle = 1'b1;
            end
            r = $urandom_range(0, 99);
            l = 1'($urandom_range(0, 1));
            pos = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 17));
            if (r < 28)      op = OP_INSERT;
            else if (r < 48) op = OP_ERASE;
            else if (r < 68) op = OP_PUSH;
            else if (r < 85) op = OP_POP;
            else if (r < 97) op = OP_READOUT;
            else             op = 3'($urandom_range(5, 7));
            queue_cmd(op, l, pos, rand_value());
            if (pending_cmds.size() > 8)
                while (pending_cmds.size() > 2)
                    @(posedge clk);
        end
        wait_drained();
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
